// File: rtl/msgd_pkg.sv
package msgd_pkg;

	// Fraction bits of every fixed-point value
	localparam int FRAC_BITS = 16;

	// Field and register widths
	localparam int VAL_W  = 24;
	localparam int GRAD_W = 32;
	localparam int L1_W   = 16;
	localparam int KEEP_W = 17;
	localparam int MOM_W  = 17;
	localparam int RATE_W = 18;
	localparam int CFG_W  = 18;
	localparam int IDX_W  = 2;

	// Velocity after the L1 step
	localparam int VADJ_W = VAL_W + 1;
	// L2 product and its scaled value
	localparam int L2P_W  = VADJ_W + KEEP_W + 1;
	localparam int VD_W   = L2P_W - FRAC_BITS;
	// Momentum product and its scaled value
	localparam int MP_W   = VD_W + MOM_W + 1;
	localparam int VM_W   = MP_W - FRAC_BITS;
	// Gradient term
	localparam int GP_W   = GRAD_W + RATE_W + 1;
	localparam int GT_W   = GP_W - FRAC_BITS;
	// New velocity before clipping
	localparam int VN_W   = ((VM_W > GT_W) ? VM_W : GT_W) + 1;

	// Register indexes
	localparam logic [IDX_W-1:0] REG_L1_STEP   = IDX_W'(0);
	localparam logic [IDX_W-1:0] REG_L2_KEEP   = IDX_W'(1);
	localparam logic [IDX_W-1:0] REG_MOMENTUM  = IDX_W'(2);
	localparam logic [IDX_W-1:0] REG_RATE      = IDX_W'(3);

	// Register reset values
	localparam logic [L1_W-1:0]   L1_RESET   = '0;
	localparam logic [KEEP_W-1:0] KEEP_RESET = KEEP_W'(1) << FRAC_BITS;
	localparam logic [MOM_W-1:0]  MOM_RESET  = '0;
	localparam logic [RATE_W-1:0] RATE_RESET = '0;

	typedef struct packed {
		logic [L1_W-1:0]   l1_step;
		logic [KEEP_W-1:0] l2_keep;
		logic [MOM_W-1:0]  momentum;
		logic [RATE_W-1:0] rate_over_batch;
	} cfg_t;

	// Classified item handed from the front to the back
	typedef struct packed {
		logic signed [VAL_W-1:0]  weight;
		logic signed [VADJ_W-1:0] vadj;
		logic signed [GRAD_W-1:0] gradient;
		logic                     is_bias;
	} item_t;

endpackage

// File: rtl/msgd_front.sv
module msgd_front (
	input  logic signed [msgd_pkg::VAL_W-1:0]  weight_in,
	input  logic signed [msgd_pkg::VAL_W-1:0]  velocity_in,
	input  logic signed [msgd_pkg::GRAD_W-1:0] gradient_in,
	input  logic                               is_bias,
	input  msgd_pkg::cfg_t                     cfg,
	output msgd_pkg::item_t                    item
);
	import msgd_pkg::*;

	logic signed [VADJ_W-1:0] v_ext;
	logic signed [VADJ_W-1:0] l1_ext;
	logic                     w_pos;
	logic                     w_neg;

	assign v_ext  = VADJ_W'(velocity_in);
	assign l1_ext = signed'(VADJ_W'(cfg.l1_step));
	assign w_neg  = weight_in[VAL_W-1];
	assign w_pos  = !w_neg && (weight_in != '0);

	// L1 step moves the velocity against the sign of the weight, pulling the weight toward zero; biases skip it
	always_comb begin
		item.weight   = weight_in;
		item.gradient = gradient_in;
		item.is_bias  = is_bias;
		if (is_bias) begin
			item.vadj = v_ext;
		end else if (w_pos) begin
			item.vadj = v_ext - l1_ext;
		end else if (w_neg) begin
			item.vadj = v_ext + l1_ext;
		end else begin
			item.vadj = v_ext;
		end
	end

endmodule

// File: rtl/msgd_queue.sv
module msgd_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  msgd_pkg::item_t push_item,
	output logic            full,
	input  logic            pop,
	output logic            pop_valid,
	output msgd_pkg::item_t pop_item
);
	import msgd_pkg::*;

	item_t      mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       do_push;
	logic       do_pop;

	assign full      = (count_q == 2'd2);
	assign pop_valid = (count_q != 2'd0);
	assign pop_item  = mem_q[rd_ptr_q];
	assign do_push   = push && !full;
	assign do_pop    = pop && pop_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 2'd1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule

// File: rtl/msgd_back.sv
module msgd_back (
	input  logic                               clk,
	input  logic                               arst_n,
	input  msgd_pkg::cfg_t                     cfg,
	input  logic                               q_valid,
	input  msgd_pkg::item_t                    q_item,
	output logic                               q_pop,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic signed [msgd_pkg::VAL_W-1:0]  weight_out,
	output logic signed [msgd_pkg::VAL_W-1:0]  velocity_out,
	output logic                               saturated
);
	import msgd_pkg::*;

	localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
	localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

	logic valid_s1, valid_s2, valid_s3, valid_s4;
	logic en1, en2, en3, en4;

	logic signed [L2P_W-1:0]  l2p_s1;
	logic signed [GP_W-1:0]   gp_s1;
	logic signed [VADJ_W-1:0] vadj_s1;
	logic                     bias_s1;
	logic signed [VAL_W-1:0]  w_s1;

	logic signed [MP_W-1:0]   mp_s2;
	logic signed [GT_W-1:0]   gt_s2;
	logic signed [VAL_W-1:0]  w_s2;

	logic signed [VAL_W-1:0]  vs_s3;
	logic                     hit_s3;
	logic signed [VAL_W-1:0]  w_s3;

	logic signed [VAL_W-1:0]  ws_s4;
	logic signed [VAL_W-1:0]  vs_s4;
	logic                     hit_s4;

	logic signed [KEEP_W:0]   keep_sx;
	logic signed [MOM_W:0]    mom_sx;
	logic signed [RATE_W:0]   rate_sx;
	logic signed [L2P_W-1:0]  l2p_d;
	logic signed [GP_W-1:0]   gp_d;
	logic signed [VD_W-1:0]   vd;
	logic signed [MP_W-1:0]   mp_d;
	logic signed [VN_W-1:0]   vn;
	logic signed [VAL_W:0]    wsum;
	logic signed [VAL_W-1:0]  vs_d;
	logic                     vhit_d;
	logic signed [VAL_W-1:0]  ws_d;
	logic                     whit_d;

	// Stage enables: a stage moves when it is empty or its successor moves
	assign en4   = !valid_s4 || !out_stall;
	assign en3   = !valid_s3 || en4;
	assign en2   = !valid_s2 || en3;
	assign en1   = !valid_s1 || en2;
	assign q_pop = q_valid && en1;

	assign keep_sx = signed'({1'b0, cfg.l2_keep});
	assign mom_sx  = signed'({1'b0, cfg.momentum});
	assign rate_sx = signed'({1'b0, cfg.rate_over_batch});

	assign l2p_d = q_item.vadj * keep_sx;
	assign gp_d  = q_item.gradient * rate_sx;

	// Biases skip the L2 scaling
	assign vd   = bias_s1 ? VD_W'(vadj_s1) : l2p_s1[L2P_W-1:FRAC_BITS];
	assign mp_d = vd * mom_sx;

	assign vn = VN_W'(signed'(mp_s2[MP_W-1:FRAC_BITS])) - VN_W'(gt_s2);

	always_comb begin
		if (vn[VN_W-1:VAL_W-1] == '0 || vn[VN_W-1:VAL_W-1] == '1) begin
			vs_d   = vn[VAL_W-1:0];
			vhit_d = 1'b0;
		end else begin
			vs_d   = vn[VN_W-1] ? VAL_MIN : VAL_MAX;
			vhit_d = 1'b1;
		end
	end

	assign wsum = (VAL_W+1)'(w_s3) + (VAL_W+1)'(vs_s3);

	always_comb begin
		if (wsum[VAL_W] == wsum[VAL_W-1]) begin
			ws_d   = wsum[VAL_W-1:0];
			whit_d = 1'b0;
		end else begin
			ws_d   = wsum[VAL_W] ? VAL_MIN : VAL_MAX;
			whit_d = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			l2p_s1  <= l2p_d;
			gp_s1   <= gp_d;
			vadj_s1 <= q_item.vadj;
			bias_s1 <= q_item.is_bias;
			w_s1    <= q_item.weight;
		end
		if (en2) begin
			mp_s2 <= mp_d;
			gt_s2 <= gp_s1[GP_W-1:FRAC_BITS];
			w_s2  <= w_s1;
		end
		if (en3) begin
			vs_s3  <= vs_d;
			hit_s3 <= vhit_d;
			w_s3   <= w_s2;
		end
		if (en4) begin
			ws_s4  <= ws_d;
			vs_s4  <= vs_s3;
			hit_s4 <= hit_s3 || whit_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (en1) begin
				valid_s1 <= q_valid;
			end
			if (en2) begin
				valid_s2 <= valid_s1;
			end
			if (en3) begin
				valid_s3 <= valid_s2;
			end
			if (en4) begin
				valid_s4 <= valid_s3;
			end
		end
	end

	assign out_valid    = valid_s4;
	assign weight_out   = ws_s4;
	assign velocity_out = vs_s4;
	assign saturated    = hit_s4;

endmodule

// File: rtl/momentum_sgd_weight_update.sv
// Momentum SGD update with L1/L2 decay, one parameter per item, signed Q8.16 data.
// Takes one item per cycle while in_stall is low and returns one result per
// item, in order. The front classifies each item by the sign of the weight and
// applies the L1 step into a two-entry queue, and the back runs it through a
// four-stage pipeline (L2 and gradient products, momentum product, velocity
// subtract and clip, weight add and clip). The pipelined back sets the rate at
// one item per cycle; an out_stall holds the back stage by stage and the queue
// absorbs the item in flight before in_stall rises. Write the registers only while
// no item is in flight.
module momentum_sgd_weight_update (
	input  logic                               clk,
	input  logic                               arst_n,
	// Configuration write port
	input  logic                               cfg_we,
	input  logic [msgd_pkg::IDX_W-1:0]         cfg_index,
	input  logic [msgd_pkg::CFG_W-1:0]         cfg_data,
	// Input channel
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic signed [msgd_pkg::VAL_W-1:0]  weight_in,
	input  logic signed [msgd_pkg::VAL_W-1:0]  velocity_in,
	input  logic signed [msgd_pkg::GRAD_W-1:0] gradient_in,
	input  logic                               is_bias,
	// Output channel
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic signed [msgd_pkg::VAL_W-1:0]  weight_out,
	output logic signed [msgd_pkg::VAL_W-1:0]  velocity_out,
	output logic                               saturated
);
	import msgd_pkg::*;

	cfg_t  cfg_q;
	item_t front_item;
	item_t q_item;
	logic  q_full;
	logic  q_valid;
	logic  q_pop;

	// Register file: out-of-list indexes cannot occur with a two-bit index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.l1_step         <= L1_RESET;
			cfg_q.l2_keep         <= KEEP_RESET;
			cfg_q.momentum        <= MOM_RESET;
			cfg_q.rate_over_batch <= RATE_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_L1_STEP:  cfg_q.l1_step         <= cfg_data[L1_W-1:0];
				REG_L2_KEEP:  cfg_q.l2_keep         <= cfg_data[KEEP_W-1:0];
				REG_MOMENTUM: cfg_q.momentum        <= cfg_data[MOM_W-1:0];
				REG_RATE:     cfg_q.rate_over_batch <= cfg_data[RATE_W-1:0];
				default: ;
			endcase
		end
	end

	// Front: classify the item and apply the L1 step
	msgd_front u_front (
		.weight_in   (weight_in),
		.velocity_in (velocity_in),
		.gradient_in (gradient_in),
		.is_bias     (is_bias),
		.cfg         (cfg_q),
		.item        (front_item)
	);

	// Queue between front and back; stall the input only when it is full
	msgd_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (in_valid),
		.push_item (front_item),
		.full      (q_full),
		.pop       (q_pop),
		.pop_valid (q_valid),
		.pop_item  (q_item)
	);

	assign in_stall = q_full;

	// Back: products, clipping and the registered result
	msgd_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.q_valid      (q_valid),
		.q_item       (q_item),
		.q_pop        (q_pop),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.weight_out   (weight_out),
		.velocity_out (velocity_out),
		.saturated    (saturated)
	);

	// Stall only with items waiting in the queue
	assert property (@(posedge clk) disable iff (!arst_n) in_stall |-> q_valid)
		else $error("input stalled with an empty queue");

	// An accepted item is held in the queue at the next edge
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> q_valid)
		else $error("accepted item lost before the queue");

	// A clipped result carries a range limit in at least one field
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && saturated) |->
		(velocity_out == {1'b0, {(VAL_W-1){1'b1}}} ||
		 velocity_out == {1'b1, {(VAL_W-1){1'b0}}} ||
		 weight_out == {1'b0, {(VAL_W-1){1'b1}}} ||
		 weight_out == {1'b1, {(VAL_W-1){1'b0}}}))
		else $error("saturated flag without a clipped value");

endmodule

// File: bench/testbench.sv
module testbench;
	import msgd_pkg::*;

	// Cycles without any item moving on either channel before the run is called dead
	localparam int STALL_LIMIT     = 1000;
	localparam int RANDOM_PHASES   = 8;
	localparam int ITEMS_PER_PHASE = 80;
	// Cycles to let pass after the last result before touching the registers
	localparam int SETTLE_CYCLES   = 8;

	typedef logic signed [VAL_W-1:0]  val_t;
	typedef logic signed [GRAD_W-1:0] grad_t;

	localparam val_t  VAL_TOP  = {1'b0, {(VAL_W-1){1'b1}}};
	localparam val_t  VAL_BOT  = {1'b1, {(VAL_W-1){1'b0}}};
	localparam val_t  VAL_ONE  = val_t'(1) <<< FRAC_BITS;
	localparam grad_t GRAD_TOP = {1'b0, {(GRAD_W-1){1'b1}}};
	localparam grad_t GRAD_BOT = {1'b1, {(GRAD_W-1){1'b0}}};

	typedef struct packed {
		val_t weight;
		val_t velocity;
		logic saturated;
	} result_t;

	// Tracks the register settings, predicts each update and checks results in order
	class update_checker;
		longint l1_step;
		longint l2_keep;
		longint momentum;
		longint rate_over_batch;
		result_t pending_updates[$];
		int mismatches;

		function new();
			l1_step = longint'(L1_RESET);
			l2_keep = longint'(KEEP_RESET);
			momentum = longint'(MOM_RESET);
			rate_over_batch = longint'(RATE_RESET);
			mismatches = 0;
		endfunction

		function void report(string msg);
			$display("ERROR at %0t: %s", $time, msg);
			mismatches++;
		endfunction

		function void set_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] data);
			case (idx)
				REG_L1_STEP:  l1_step = longint'(data[L1_W-1:0]);
				REG_L2_KEEP:  l2_keep = longint'(data[KEEP_W-1:0]);
				REG_MOMENTUM: momentum = longint'(data[MOM_W-1:0]);
				REG_RATE:     rate_over_batch = longint'(data[RATE_W-1:0]);
				default: ;
			endcase
		endfunction

		function longint clip(longint x, inout bit hit);
			if (x > longint'(VAL_TOP)) begin
				hit = 1'b1;
				return longint'(VAL_TOP);
			end
			if (x < longint'(VAL_BOT)) begin
				hit = 1'b1;
				return longint'(VAL_BOT);
			end
			return x;
		endfunction

		// Work out the updated weight and velocity of one accepted item
		function void note_item(val_t w, val_t v, grad_t g, logic bias);
			longint wl;
			longint vl;
			longint gl;
			longint vs;
			longint ws;
			bit hit;
			result_t r;
			wl = w;
			vl = v;
			gl = g;
			hit = 1'b0;
			if (!bias) begin
				// L1 moves the velocity against the sign of the weight
				if (wl > 0)
					vl = vl - l1_step;
				else if (wl < 0)
					vl = vl + l1_step;
				vl = (vl * l2_keep) >>> FRAC_BITS;
			end
			vl = (vl * momentum) >>> FRAC_BITS;
			vl = vl - ((gl * rate_over_batch) >>> FRAC_BITS);
			vs = clip(vl, hit);
			ws = clip(wl + vs, hit);
			r.weight = val_t'(ws);
			r.velocity = val_t'(vs);
			r.saturated = hit;
			pending_updates = {pending_updates, r};
		endfunction

		function void check_result(val_t w, val_t v, logic sat);
			result_t want;
			if (pending_updates.size() == 0) begin
				report($sformatf("result with nothing pending: weight %0d velocity %0d", w, v));
				return;
			end
			want = pending_updates.pop_front();
			if (w !== want.weight)
				report($sformatf("weight_out %0d, want %0d", w, want.weight));
			if (v !== want.velocity)
				report($sformatf("velocity_out %0d, want %0d", v, want.velocity));
			if (sat !== want.saturated)
				report($sformatf("saturated %0b, want %0b", sat, want.saturated));
		endfunction
	endclass

	logic             clk;
	logic             arst_n;
	logic             cfg_we;
	logic [IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0] cfg_data;
	logic             in_valid;
	logic             in_stall;
	val_t             weight_in;
	val_t             velocity_in;
	grad_t            gradient_in;
	logic             is_bias;
	logic             out_valid;
	logic             out_stall;
	val_t             weight_out;
	val_t             velocity_out;
	logic             saturated;

	update_checker book;
	// Phase with no sender gaps and no new receiver stall bursts
	bit quiet;
	int hold_left;
	int idle_cycles;

	momentum_sgd_weight_update dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.weight_in    (weight_in),
		.velocity_in  (velocity_in),
		.gradient_in  (gradient_in),
		.is_bias      (is_bias),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.weight_out   (weight_out),
		.velocity_out (velocity_out),
		.saturated    (saturated)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// Idle length drawn from three ranges: mostly the shortest, now and then the longest
	function int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return $urandom_range(1, 2);
		if (r < 95)
			return $urandom_range(3, 8);
		return $urandom_range(20, 60);
	endfunction

	// Weights and velocities: extremes, full range, or values near zero
	function val_t pick_value();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0) begin
			case ($urandom_range(0, 4))
				0: return VAL_TOP;
				1: return VAL_BOT;
				2: return val_t'(0);
				3: return val_t'(1);
				default: return val_t'(-1);
			endcase
		end
		if (r < 3)
			return val_t'($urandom);
		return val_t'(int'($urandom_range(0, 524288)) - 262144);
	endfunction

	// Gradients: keep most small so that the update rarely saturates
	function grad_t pick_gradient();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0) begin
			case ($urandom_range(0, 3))
				0: return GRAD_TOP;
				1: return GRAD_BOT;
				2: return grad_t'(0);
				default: return grad_t'(-1);
			endcase
		end
		if (r < 3)
			return grad_t'($urandom);
		return grad_t'(int'($urandom_range(0, 2097152)) - 1048576);
	endfunction

	// Write all four registers on successive cycles, then drop the write enable
	task automatic load_config(logic [CFG_W-1:0] l1, logic [CFG_W-1:0] keep,
			logic [CFG_W-1:0] mom, logic [CFG_W-1:0] rate);
		logic [CFG_W-1:0] vals [4];
		logic [IDX_W-1:0] regs [4];
		vals = '{l1, keep, mom, rate};
		regs = '{REG_L1_STEP, REG_L2_KEEP, REG_MOMENTUM, REG_RATE};
		for (int i = 0; i < 4; i++) begin
			@(negedge clk);
			cfg_we = 1'b1;
			cfg_index = regs[i];
			cfg_data = vals[i];
			book.set_reg(regs[i], vals[i]);
		end
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	// Present one item after an optional gap and hold it until the block takes it
	task automatic send(val_t w, val_t v, grad_t g, logic bias, int gap);
		if (gap > 0) begin
			@(negedge clk);
			in_valid = 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_valid = 1'b1;
		weight_in = w;
		velocity_in = v;
		gradient_in = g;
		is_bias = bias;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	// Drop valid, then wait for every pending result and let the pipeline settle
	task automatic drain();
		@(negedge clk);
		in_valid = 1'b0;
		while (book.pending_updates.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Note every accepted item and check every accepted result at the rising edge
	always @(posedge clk) begin
		if (arst_n && in_valid && !in_stall)
			book.note_item(weight_in, velocity_in, gradient_in, is_bias);
		if (arst_n && out_valid && !out_stall)
			book.check_result(weight_out, velocity_out, saturated);
	end

	// Receiver side: stall in bursts of random length, starting none in a quiet phase
	initial begin
		out_stall = 1'b0;
		hold_left = 0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				out_stall = 1'b1;
				hold_left--;
			end else begin
				out_stall = 1'b0;
				if (!quiet && $urandom_range(0, 3) == 0)
					hold_left = idle_len();
			end
		end
	end

	// Watchdog: end the run when nothing moves for too long
	initial begin
		idle_cycles = 0;
		while (idle_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		book = new();
		quiet = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		weight_in = '0;
		velocity_in = '0;
		gradient_in = '0;
		is_bias = 1'b0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: mu about 0.9, eta/m about 0.1, visible L1 and L2 decay
		load_config(18'd3000, 18'd60000, 18'd58982, 18'd6554);
		// Sign of the weight: positive, negative and zero, as weight and as bias
		send(VAL_ONE, VAL_ONE >>> 1, grad_t'(16384), 1'b0, 0);
		send(-VAL_ONE, VAL_ONE >>> 1, grad_t'(16384), 1'b0, 0);
		send(val_t'(0), VAL_ONE >>> 1, grad_t'(-16384), 1'b0, 0);
		send(VAL_ONE, VAL_ONE >>> 1, grad_t'(16384), 1'b1, 0);
		send(-VAL_ONE, -(VAL_ONE >>> 1), grad_t'(16384), 1'b1, 0);
		send(val_t'(0), val_t'(0), grad_t'(0), 1'b1, 0);
		send(val_t'(1), val_t'(-1), grad_t'(1), 1'b0, 0);
		send(val_t'(-1), val_t'(1), grad_t'(-1), 1'b0, 0);
		// Velocity and weight pushed past both ends of the range
		send(VAL_TOP, VAL_TOP, GRAD_BOT, 1'b0, 0);
		send(VAL_BOT, VAL_BOT, GRAD_TOP, 1'b0, 0);
		send(VAL_TOP, VAL_TOP, GRAD_BOT, 1'b1, 0);
		send(VAL_BOT, VAL_BOT, GRAD_TOP, 1'b1, 0);
		// Weight clips while the velocity stays in range; then each input alone at an extreme
		send(VAL_TOP, VAL_ONE, grad_t'(-65536), 1'b1, 0);
		send(VAL_BOT, -VAL_ONE, grad_t'(65536), 1'b1, 0);
		send(VAL_TOP, val_t'(0), grad_t'(0), 1'b0, 0);
		send(VAL_BOT, val_t'(0), grad_t'(0), 1'b0, 0);
		send(val_t'(0), VAL_TOP, grad_t'(0), 1'b0, 0);
		send(val_t'(0), VAL_BOT, grad_t'(0), 1'b0, 0);
		send(val_t'(0), val_t'(0), GRAD_TOP, 1'b0, 0);
		send(val_t'(0), val_t'(0), GRAD_BOT, 1'b0, 0);
		drain();

		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			case (phase)
				// Every register at the top of its width
				0: load_config(18'h0FFFF, 18'h1FFFF, 18'h1FFFF, 18'h3FFFF);
				1: load_config(18'd0, 18'd0, 18'd0, 18'd0);
				// Top of the stated ranges
				2: load_config(18'd65535, 18'd65536, 18'd65536, 18'd262143);
				3: load_config(18'd0, 18'd65536, 18'd65536, 18'd0);
				default: load_config(18'($urandom_range(0, 65535)),
						18'($urandom_range(0, 65536)), 18'($urandom_range(0, 65536)),
						18'($urandom_range(0, 262143)));
			endcase
			quiet = (phase == 5);
			for (int n = 0; n < ITEMS_PER_PHASE; n++)
				send(pick_value(), pick_value(), pick_gradient(),
					logic'($urandom_range(0, 3) == 0),
					(!quiet && $urandom_range(0, 2) == 0) ? idle_len() : 0);
			drain();
			quiet = 1'b0;
		end

		if (book.mismatches == 0 && book.pending_updates.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
